FILE: src/b64e_pkg.sv
`timescale 1ns / 1ps
// Package for the base64 encoder with plus escaping.
// Holds the ASCII codes and the sextet-to-character alphabet; no dependencies.
package b64e_pkg;

    localparam logic [7:0] CHR_PLUS    = 8'h2B;  // '+'
    localparam logic [7:0] CHR_PERCENT = 8'h25;  // '%'
    localparam logic [7:0] CHR_TWO     = 8'h32;  // '2'
    localparam logic [7:0] CHR_UPPER_B = 8'h42;  // 'B'
    localparam logic [7:0] CHR_PAD     = 8'h3D;  // '='
    localparam logic [7:0] CHR_UPPER_A = 8'h41;  // 'A'
    localparam logic [7:0] CHR_LOWER_A = 8'h61;  // 'a'
    localparam logic [7:0] CHR_ZERO    = 8'h30;  // '0'
    localparam logic [7:0] CHR_SLASH   = 8'h2F;  // '/'

    localparam logic [5:0] SEXTET_MASK = 6'h3F;
    localparam logic       ESCAPE_RESET = 1'b1;

    // Escape expansion steps for one '+'
    localparam logic [1:0] SUB_PERCENT = 2'd0;
    localparam logic [1:0] SUB_TWO     = 2'd1;
    localparam logic [1:0] SUB_B       = 2'd2;

    typedef logic [7:0] t_char;

    // Standard alphabet: A-Z a-z 0-9 + /
    function automatic t_char b64_char(input logic [5:0] sextet);
        t_char c;
        c = CHR_SLASH;
        case (sextet) inside
            [6'd0:6'd25]:  c = CHR_UPPER_A + {2'b00, sextet};
            [6'd26:6'd51]: c = CHR_LOWER_A + {2'b00, sextet} - 8'd26;
            [6'd52:6'd61]: c = CHR_ZERO + {2'b00, sextet} - 8'd52;
            6'd62:         c = CHR_PLUS;
            default:       c = CHR_SLASH;
        endcase
        return c;
    endfunction

endpackage

FILE: src/base64_encoder_plus_escape_top.sv
`timescale 1ns / 1ps
// Base64 encoder with optional '+' -> "%2B" escaping, top level.
// Depends on b64e_pkg for the alphabet and character codes.
//
//  channel   signals                                   direction
//  -------   ----------------------------------------  ---------
//  in        i_in_valid/o_in_ready, i_data_byte,        sink
//            i_last_byte
//  out       o_out_valid/i_out_ready, o_out_char,       source
//            o_last_char
//  cfg       i_cfg_valid/o_cfg_ready, i_cfg_escape_plus sink
//
// A byte that only fills the hold register is shifted into it when taken.
// A byte that closes a group loads four characters into the group register in
// that cycle; they drain one per cycle through the output register while it is
// not stalled; escaping expands each '+' to "%2B". The next byte is taken in
// the cycle the last character of a group moves to the output register.
// Synchronous active-low reset clears held bytes, group and output state and
// sets escaping on. Output stalls hold the output register and the group.
module base64_encoder_plus_escape_top
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_last_char,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_escape_plus
);

    logic        r_escape;
    logic [15:0] r_held_bytes;
    logic [1:0]  r_held_count;

    t_char       r_grp_char [4];
    logic        r_grp_valid;
    logic        r_grp_last;
    logic [1:0]  r_grp_idx;
    logic [1:0]  r_sub;

    logic        r_out_valid;
    t_char       r_out_char;
    logic        r_out_last;

    logic        in_xfer;
    logic        two_held;
    logic        grp_load;
    logic [23:0] triple;
    t_char       n_grp_char [4];
    logic [1:0]  n_held_count;

    logic        advance;
    t_char       cur_char;
    logic        cur_esc;
    logic        piece_end;
    logic        grp_done;
    t_char       n_out_char;

    // ---------------- group formation ----------------
    assign two_held = r_held_count[1];
    assign in_xfer  = i_in_valid && o_in_ready;
    assign grp_load = in_xfer && (two_held || i_last_byte);

    always_comb begin
        if (two_held) begin
            triple = {r_held_bytes, i_data_byte};
        end else if (r_held_count[0]) begin
            triple = {r_held_bytes[7:0], i_data_byte, 8'h00};
        end else begin
            triple = {i_data_byte, 16'h0000};
        end
        for (int k = 0; k < 4; k++) begin
            n_grp_char[k] = b64_char(triple[18 - 6 * k +: 6] & SEXTET_MASK);
        end
        // pad the tail of a short final group
        if (!two_held) begin
            n_grp_char[3] = CHR_PAD;
            if (!r_held_count[0]) begin
                n_grp_char[2] = CHR_PAD;
            end
        end
        n_held_count = two_held ? 2'd2 : r_held_count + 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bytes <= '0;
            r_held_count <= '0;
        end else if (in_xfer) begin
            if (grp_load) begin
                r_held_bytes <= '0;
                r_held_count <= '0;
            end else begin
                r_held_bytes <= {r_held_bytes[7:0], i_data_byte};
                r_held_count <= n_held_count;
            end
        end
    end

    // ---------------- config ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape <= ESCAPE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_escape <= i_cfg_escape_plus;
        end
    end

    // ---------------- drain ----------------
    assign advance   = r_grp_valid && (!r_out_valid || i_out_ready);
    assign cur_char  = r_grp_char[r_grp_idx];
    assign cur_esc   = r_escape && (cur_char == CHR_PLUS);
    assign piece_end = !cur_esc || (r_sub == SUB_B);
    assign grp_done  = advance && piece_end && (r_grp_idx == 2'd3);
    assign o_in_ready = !r_grp_valid || grp_done;

    always_comb begin
        n_out_char = cur_char;
        if (cur_esc) begin
            case (r_sub)
                SUB_PERCENT: n_out_char = CHR_PERCENT;
                SUB_TWO:     n_out_char = CHR_TWO;
                default:     n_out_char = CHR_UPPER_B;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_valid <= 1'b0;
            r_grp_idx   <= '0;
            r_sub       <= SUB_PERCENT;
        end else begin
            if (grp_load) begin
                r_grp_valid <= 1'b1;
                r_grp_idx   <= '0;
                r_sub       <= SUB_PERCENT;
            end else if (advance) begin
                if (!piece_end) begin
                    r_sub <= r_sub + 2'd1;
                end else begin
                    r_sub     <= SUB_PERCENT;
                    r_grp_idx <= r_grp_idx + 2'd1;
                    if (r_grp_idx == 2'd3) begin
                        r_grp_valid <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (grp_load) begin
            r_grp_char <= n_grp_char;
            r_grp_last <= i_last_byte;
        end
    end

    // output register: load on advance, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_char <= n_out_char;
            r_out_last <= r_grp_last && piece_end && (r_grp_idx == 2'd3);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

    // ---------------- checks ----------------
    a_held_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_count != 2'd3)
        else $error("held count reached three");

    a_load_clears_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        grp_load |=> (r_held_count == 2'd0) && r_grp_valid)
        else $error("group load did not clear held bytes");

    a_escape_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub != SUB_PERCENT) |-> r_grp_valid)
        else $error("escape step outside an active group");

    a_percent_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_char == CHR_PERCENT) |-> r_grp_valid)
        else $error("percent shown without rest of escape pending");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_grp_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while group stalled");

endmodule

FILE: dv/base64_encoder_plus_escape_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for base64_encoder_plus_escape_top: directed groups,
// escape on and off, then random byte streams. Depends on b64e_pkg.
module base64_encoder_plus_escape_top_tb;
    import b64e_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_enc_char;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_data_byte;
    logic       i_last_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_char;
    logic       o_last_char;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_escape_plus;

    base64_encoder_plus_escape_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_char        (o_out_char),
        .o_last_char       (o_last_char),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_escape_plus (i_cfg_escape_plus)
    );

    // Encoder mirror
    string      b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    logic       escape_on;
    logic [15:0] pending_bytes;
    logic [1:0] pending_count;
    t_enc_char  expected_chars[$];

    int  cycle_count = 0;
    int  error_count = 0;
    int  bytes_sent = 0;
    int  chars_checked = 0;
    int  cfg_writes = 0;
    bit  steady_mode = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d chars still expected", $time, expected_chars.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver stalls about 11% of cycles unless in a steady stretch
    always @(posedge i_clk) begin
        i_out_ready <= steady_mode ? 1'b1 : ($urandom_range(0, 99) >= 11);
    end

    // Valid and ready are stable at the falling edge, so a transfer seen here
    // completes at the next rising edge.
    always @(negedge i_clk) begin
        t_enc_char exp_c;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected char: expected none, actual %h last %b",
                         $time, o_out_char, o_last_char);
                error_count++;
            end else begin
                exp_c = expected_chars.pop_front();
                if (o_out_char !== exp_c.ch) begin
                    $display("%0t: out_char mismatch: expected %h actual %h",
                             $time, exp_c.ch, o_out_char);
                    error_count++;
                end
                if (o_last_char !== exp_c.last) begin
                    $display("%0t: last_char mismatch: expected %b actual %b",
                             $time, exp_c.last, o_last_char);
                    error_count++;
                end
            end
        end
    end

    // Update the mirror for one accepted byte and queue the characters it yields
    task automatic encode_byte(input logic [7:0] b, input logic lst);
        t_enc_char  grp_chars[$];
        logic [1:0] cnt;
        logic [23:0] triple;
        logic [5:0] sextet;
        logic [7:0] c;
        int         total;
        cnt = pending_count;
        if (cnt == 2'd3) cnt = 2'd2;
        if (cnt < 2'd2 && !lst) begin
            pending_bytes = {pending_bytes[7:0], b};
            pending_count = cnt + 2'd1;
            return;
        end
        case (cnt)
            2'd2:    triple = {pending_bytes, b};
            2'd1:    triple = {pending_bytes[7:0], b, 8'h00};
            default: triple = {b, 16'h0000};
        endcase
        total = cnt + 1;
        for (int k = 0; k < 4; k++) begin
            if (k <= total) begin
                sextet = triple[18 - 6 * k +: 6];
                c = b64_alphabet[sextet];
                if (c == CHR_PLUS && escape_on) begin
                    grp_chars.push_back('{ch: CHR_PERCENT, last: 1'b0});
                    grp_chars.push_back('{ch: CHR_TWO, last: 1'b0});
                    grp_chars.push_back('{ch: CHR_UPPER_B, last: 1'b0});
                end else begin
                    grp_chars.push_back('{ch: c, last: 1'b0});
                end
            end else begin
                grp_chars.push_back('{ch: CHR_PAD, last: 1'b0});
            end
        end
        grp_chars[grp_chars.size() - 1].last = lst;
        foreach (grp_chars[i]) expected_chars.push_back(grp_chars[i]);
        pending_bytes = 16'h0000;
        pending_count = 2'd0;
    endtask

    // Called at a rising edge; returns at the edge of the transfer with valid
    // still high, so the next call may present its byte in the same step.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        if (!steady_mode && $urandom_range(0, 99) < 11) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= lst;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        encode_byte(b, lst);
        bytes_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_escape(input logic value);
        wait_idle();
        i_cfg_valid       <= 1'b1;
        i_cfg_escape_plus <= value;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        escape_on = value;
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // Escaping is on out of reset; groups rich in '+' plus the byte extremes
    task automatic test_escape_default();
        send_byte(8'hF8, 1'b1);                      // one-byte tail, '+' and 'A' then "=="
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b1);                      // two-byte tail, two '+'
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);                      // "++++" expands to 12 chars
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // full group mid-stream, then lone final bytes
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        wait_idle();
    endtask

    task automatic test_escape_disabled();
        write_escape(1'b0);
        send_byte(8'hF8, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
        send_byte(8'h3E, 1'b0);
        send_byte(8'hE0, 1'b1);
        wait_idle();
    endtask

    // Streams of random length; about a third of the bytes are biased to give '+'
    task automatic test_random_streams(input int n_items);
        int          left;
        int          len;
        logic [7:0]  b;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
            if (len > left) len = left;
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 99) < 30) begin
                    case ($urandom_range(0, 5))
                        0:       b = 8'hF8;
                        1:       b = 8'hFB;
                        2:       b = 8'hEF;
                        3:       b = 8'hBE;
                        4:       b = 8'h3E;
                        default: b = 8'hE0;
                    endcase
                end else begin
                    b = 8'($urandom_range(0, 255));
                end
                send_byte(b, i == len - 1);
            end
            left -= len;
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_data_byte       <= 8'h00;
        i_last_byte       <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_cfg_escape_plus <= 1'b0;
        escape_on     = ESCAPE_RESET;
        pending_bytes = 16'h0000;
        pending_count = 2'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_escape_default();
        test_escape_disabled();
        write_escape(1'b1);
        test_random_streams(100);
        write_escape(1'b0);
        test_random_streams(80);
        // long stretch with no stalls on either side
        steady_mode = 1'b1;
        write_escape(1'b1);
        test_random_streams(60);
        steady_mode = 1'b0;
        write_escape(1'b0);
        test_random_streams(80);

        $display("Encoded %0d bytes into %0d checked chars across %0d escape settings",
                 bytes_sent, chars_checked, cfg_writes);
        $display("Mismatches found: %0d", error_count);
        if (error_count == 0 && expected_chars.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
